>>> rtl/core/srp_pkg.sv
// Shared types, constants and helper functions for the sparse row projector.
// Depends on nothing; every other file of the block but srp_voxel_ram imports it.
`default_nettype none

package srp_pkg;

    // Image geometry and value range
    localparam int PLANES     = 64;
    localparam int IMAGE_SIDE = 128;
    localparam int VALUE_BITS = 32;

    localparam int VOXELS   = PLANES * IMAGE_SIDE * IMAGE_SIDE;
    localparam int ADDR_W   = $clog2(VOXELS);
    localparam int SIDE_LOG = $clog2(IMAGE_SIDE);
    localparam int COORD_W  = (SIDE_LOG > 7 ? SIDE_LOG : 7) + 2;

    // Field widths
    localparam int PLANE_W  = 8;
    localparam int RC_W     = 7;
    localparam int WEIGHT_W = 16;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 1;

    // Arithmetic widths: product is Q24.24, term is Q24.16 after the floor shift
    localparam int PROD_W = VALUE_W + WEIGHT_W + 1;
    localparam int TERM_W = PROD_W - 8;
    localparam int ACC_W  = 48;
    localparam int SUM_W  = ACC_W + 2;

    // Saturation bounds
    localparam int VB_EFF = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (VB_EFF - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PLANE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PLANE = 1'b1;
    localparam logic [CFG_W-1:0] MIN_PLANE_RST = 6'd0;
    localparam logic [CFG_W-1:0] MAX_PLANE_RST = 6'd63;

    // Result kinds
    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FWD   = 2'd2,
        OP_BACK  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               kind;
        logic               sat;
    } t_result;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               clip;
    } t_sat;

    // Clip a wide sum to the voxel value range
    function automatic t_sat sat_value(input logic signed [SUM_W-1:0] x);
        t_sat s;
        if (x > SAT_HI) begin
            s.value = SAT_HI[VALUE_W-1:0];
            s.clip  = 1'b1;
        end else if (x < SAT_LO) begin
            s.value = SAT_LO[VALUE_W-1:0];
            s.clip  = 1'b1;
        end else begin
            s.value = x[VALUE_W-1:0];
            s.clip  = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/srp_voxel_ram.sv
// Generic single-port-write, single-port-read synchronous RAM for voxel data.
// Read data is registered. No dependencies.
`default_nettype none

module srp_voxel_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/srp_outbuf.sv
// Output register holding one result item until the consumer takes it.
// Depends on srp_pkg for the result struct.
`default_nettype none

module srp_outbuf
    import srp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_valid;
    t_result r_data;

    assign o_can_push = !r_valid || i_ready;

    // Hold the item until taken; load a new one whenever the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_can_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_can_push) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/core/srp_engine.sv
// Item sequencer and arithmetic: address check, voxel read-modify-write,
// row accumulator and plane range registers. Depends on srp_pkg.
`default_nettype none

module srp_engine
    import srp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    // input items
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [1:0]             i_opcode,
    input  wire logic signed [PLANE_W-1:0] i_plane,
    input  wire logic signed [RC_W-1:0] i_row,
    input  wire logic signed [RC_W-1:0] i_col,
    input  wire logic [WEIGHT_W-1:0]    i_weight,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                   i_last,
    // result push
    output logic                        o_push,
    output t_result                     o_result,
    input  wire logic                   i_can_push,
    // voxel memory
    output logic                        o_ram_we,
    output logic [ADDR_W-1:0]           o_ram_waddr,
    output logic [VALUE_W-1:0]          o_ram_wdata,
    output logic                        o_ram_re,
    output logic [ADDR_W-1:0]           o_ram_raddr,
    input  wire logic [VALUE_W-1:0]     i_ram_rdata
);

    t_state  r_state, n_state;
    t_opcode r_op;
    logic [ADDR_W-1:0]           r_addr;
    logic                        r_ok;
    logic [WEIGHT_W-1:0]         r_weight;
    logic signed [VALUE_W-1:0]   r_value;
    logic                        r_last;
    logic signed [VALUE_W-1:0]   r_vox;
    logic signed [TERM_W-1:0]    r_term;
    logic signed [ACC_W-1:0]     r_acc;
    logic [CFG_W-1:0]            r_min_plane;
    logic [CFG_W-1:0]            r_max_plane;

    logic accept, acc_upd, acc_clr, mul_load;
    logic ok_c, ok_plane, ok_row, ok_col;
    logic signed [COORD_W-1:0]   ri_c, ci_c;
    logic [ADDR_W-1:0]           addr_c;
    logic signed [VALUE_W-1:0]   mul_a;
    logic signed [PROD_W-1:0]    prod_c;
    logic signed [SUM_W-1:0]     acc_sum, back_sum, fin_sum;
    logic signed [ACC_W-1:0]     acc_next;
    t_sat                        wr_sat, back_sat, fin_sat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_plane <= MIN_PLANE_RST;
            r_max_plane <= MAX_PLANE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_PLANE: r_min_plane <= i_cfg_data;
                CFG_MAX_PLANE: r_max_plane <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Range check and voxel address of the incoming item
    always_comb begin
        ri_c = COORD_W'(i_row) + COORD_W'(IMAGE_SIDE / 2);
        ci_c = COORD_W'(i_col) + COORD_W'(IMAGE_SIDE / 2);
        ok_plane = !i_plane[PLANE_W-1]
                && ({1'b0, i_plane} < (PLANE_W + 1)'(PLANES))
                && ({(PLANE_W - CFG_W)'(0), r_min_plane} <= i_plane)
                && ({(PLANE_W - CFG_W)'(0), r_max_plane} >= i_plane);
        ok_row = !ri_c[COORD_W-1] && ($unsigned(ri_c) < COORD_W'(IMAGE_SIDE));
        ok_col = !ci_c[COORD_W-1] && ($unsigned(ci_c) < COORD_W'(IMAGE_SIDE));
        ok_c   = ok_plane && ok_row && ok_col;
        addr_c = ADDR_W'(ADDR_W'($unsigned(i_plane)) * ADDR_W'(IMAGE_SIDE) * ADDR_W'(IMAGE_SIDE)
               + ADDR_W'($unsigned(ri_c)) * ADDR_W'(IMAGE_SIDE)
               + ADDR_W'($unsigned(ci_c)));
    end

    assign accept = i_valid && o_ready;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_addr   <= addr_c;
            r_ok     <= ok_c;
            r_weight <= i_weight;
            r_value  <= i_value;
            r_last   <= i_last;
        end
    end

    // Product stage: voxel * weight for forward items, weight * bin value otherwise
    assign mul_a  = (r_op == OP_FWD) ? $signed(i_ram_rdata) : r_value;
    assign prod_c = mul_a * $signed({1'b0, r_weight});

    always_ff @(posedge i_clk) begin
        if (mul_load) begin
            r_vox  <= $signed(i_ram_rdata);
            r_term <= prod_c[PROD_W-1:8];
        end
    end

    // Accumulator update, write data and row result
    always_comb begin
        acc_sum  = SUM_W'(r_acc) + SUM_W'(r_term);
        if (acc_sum > ACC_HI) begin
            acc_next = ACC_HI[ACC_W-1:0];
        end else if (acc_sum < ACC_LO) begin
            acc_next = ACC_LO[ACC_W-1:0];
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        back_sum = SUM_W'(r_vox) + SUM_W'(r_term);
        fin_sum  = SUM_W'(r_value) + SUM_W'(r_acc);
        wr_sat   = sat_value(SUM_W'(r_value));
        back_sat = sat_value(back_sum);
        fin_sat  = sat_value(fin_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (acc_clr) begin
            r_acc <= '0;
        end else if (acc_upd && r_ok) begin
            r_acc <= acc_next;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (t_opcode'(i_opcode) == OP_WRITE) ? ST_UPD : ST_READ;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_UPD;
            ST_UPD: begin
                case (r_op)
                    OP_READ: n_state = i_can_push ? ST_IDLE : ST_UPD;
                    OP_FWD:  n_state = r_last ? ST_FIN : ST_IDLE;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_FIN:  n_state = i_can_push ? ST_IDLE : ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready     = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_wdata = wr_sat.value;
        o_push      = 1'b0;
        o_result    = '{value: '0, kind: KIND_VOXEL, sat: 1'b0};
        mul_load    = 1'b0;
        acc_upd     = 1'b0;
        acc_clr     = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_READ: o_ram_re = 1'b1;
            ST_MUL:  mul_load = 1'b1;
            ST_UPD: begin
                case (r_op)
                    OP_WRITE: o_ram_we = r_ok;
                    OP_READ: begin
                        o_push   = 1'b1;
                        o_result = '{value: (r_ok ? r_vox : '0), kind: KIND_VOXEL, sat: 1'b0};
                    end
                    OP_FWD:  acc_upd = 1'b1;
                    OP_BACK: begin
                        o_ram_we    = r_ok && (r_value != '0);
                        o_ram_wdata = back_sat.value;
                    end
                    default: ;
                endcase
            end
            ST_FIN: begin
                o_push   = 1'b1;
                o_result = '{value: fin_sat.value, kind: KIND_BIN, sat: fin_sat.clip};
                acc_clr  = i_can_push;
            end
            default: ;
        endcase
    end

    assign o_ram_waddr = r_addr;
    assign o_ram_raddr = r_addr;

endmodule

`default_nettype wire

>>> rtl/core/sparse_row_projector_top.sv
// Results: a read item passes READ, MUL and UPD and pushes its voxel in UPD;
// a forward item carrying last passes READ, MUL, UPD and FIN and pushes its
// bin in FIN; other items emit nothing. Items are taken one at a time: a write
// passes UPD only, the others the read / multiply / write-back sequence on the
// single voxel memory port; a full output register stalls a result-bearing item.
// Reset (synchronous, active low) clears control and accumulator and resets the plane range.
`default_nettype none

module sparse_row_projector_top
    import srp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_opcode,
    input  wire logic signed [PLANE_W-1:0] i_plane,
    input  wire logic signed [RC_W-1:0]    i_row,
    input  wire logic signed [RC_W-1:0]    i_col,
    input  wire logic [WEIGHT_W-1:0]       i_weight,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_last,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [VALUE_W-1:0]      o_result_value,
    output logic                           o_result_kind,
    output logic                           o_saturated
);

    logic               push, can_push;
    t_result            eng_result, out_result;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    srp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_plane     (i_plane),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_weight    (i_weight),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_push      (push),
        .o_result    (eng_result),
        .i_can_push  (can_push),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    srp_voxel_ram #(
        .DEPTH  (VOXELS),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    srp_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (eng_result),
        .o_can_push (can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (out_result)
    );

    assign o_result_value = $signed(out_result.value);
    assign o_result_kind  = out_result.kind;
    assign o_saturated    = out_result.sat;

endmodule

`default_nettype wire

>>> rtl/core/srp_checker.sv
// Port-level checks for the sparse row projector, bound to the top level.
// Depends on srp_pkg and sparse_row_projector_top.
`default_nettype none

module srp_port_checker
    import srp_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic signed [VALUE_W-1:0] o_result_value,
    input wire logic                      o_result_kind,
    input wire logic                      o_saturated
);

    // Held result stays put while the consumer stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_value)
            && $stable(o_result_kind) && $stable(o_saturated)))
        else $error("result item changed while stalled");

    // Idle with no result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("not idle after reset");

    // One item at a time: no acceptance in the cycle after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another is in progress");

    // A fresh result only comes from an item in progress
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result item appeared without an item in progress");

    // Voxel reads are never clipped
    a_read_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_VOXEL) |-> !o_saturated)
        else $error("voxel read item flagged as saturated");

endmodule

bind sparse_row_projector_top srp_port_checker u_checker (.*);

`default_nettype wire
